@@ hdl/msk_pkg.sv @@
// Package for the sketch update block: word types of both channels,
// field widths, request codes, register index and controller states.
// No dependencies.
package msk_pkg;

   localparam int WORD_W   = 32;
   localparam int HASH_W   = 64;
   localparam int IDX_W    = 8;
   localparam int COUNT_W  = 9;
   localparam int ACTIVE_W = 9;
   localparam int KIND_W   = 3;
   localparam int PDATA_W  = 32;
   localparam int PADDR_W  = 3;

   localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 9'd256;
   localparam logic [COUNT_W-1:0]  COUNT_MAX    = 9'd511;

   // Request codes.
   localparam logic [KIND_W-1:0] REQ_ADD     = 3'd0;
   localparam logic [KIND_W-1:0] REQ_MERGE   = 3'd1;
   localparam logic [KIND_W-1:0] REQ_COMPARE = 3'd2;
   localparam logic [KIND_W-1:0] REQ_READ    = 3'd3;
   localparam logic [KIND_W-1:0] REQ_WRITE   = 3'd4;

   // Word index of the active register count (paddr bit 2).
   localparam logic CSR_ACTIVE_IDX = 1'b0;

   typedef struct packed {
      logic [KIND_W-1:0]  req_type;
      logic [HASH_W-1:0]  key_hash;
      logic [IDX_W-1:0]   reg_index;
      logic [WORD_W-1:0]  reg_value;
      logic               restart_count;
   } req_word_type;

   typedef struct packed {
      logic [WORD_W-1:0]  read_value;
      logic               match;
      logic [COUNT_W-1:0] match_count;
      logic               index_error;
   } rsp_word_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ADD,
      ST_DRAIN,
      ST_LOOKUP,
      ST_MODIFY,
      ST_DONE
   } eng_state_type;

endpackage

@@ hdl/msk_mem.sv @@
// Sketch word store: one write port, one read port, registered read data.
// Depends on msk_pkg for the word width.
module msk_mem
   import msk_pkg::*;
#(
   parameter int DEPTH = 256
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WORD_W-1:0]                         wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WORD_W-1:0]                         rd_data
);

   logic [WORD_W-1:0] words_ff [DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         words_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= words_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/msk_engine.sv @@
// Controller and datapath of the sketch update block: clearing pass, add sweep,
// indexed read-modify-write and the running equal count.
// Depends on msk_pkg; drives the ports of msk_mem.
module msk_engine
   import msk_pkg::*;
#(
   parameter int MAX_REGS = 256
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic [ACTIVE_W-1:0]                          active_regs,
   input  logic                                         req_valid,
   output logic                                         req_ready,
   input  req_word_type                                 req_word,
   output logic                                         res_valid,
   input  logic                                         res_take,
   output rsp_word_type                                 res_word,
   output logic                                         mem_wr_en,
   output logic [((MAX_REGS > 1) ? $clog2(MAX_REGS) : 1)-1:0] mem_wr_addr,
   output logic [WORD_W-1:0]                            mem_wr_data,
   output logic                                         mem_rd_en,
   output logic [((MAX_REGS > 1) ? $clog2(MAX_REGS) : 1)-1:0] mem_rd_addr,
   input  logic [WORD_W-1:0]                            mem_rd_data
);

   localparam int AW = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1;
   localparam int IW = (AW + 1 > ACTIVE_W) ? AW + 1 : ACTIVE_W;
   localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_REGS - 1);

   eng_state_type      state_ff, state_in;
   logic [IW-1:0]      cnt_ff, cnt_in;
   logic [IW-1:0]      n_eff;
   logic [WORD_W-1:0]  hash_ff, hash_in;
   logic [WORD_W-1:0]  step_ff, step_in;
   logic               pipe_valid_ff, pipe_valid_in;
   logic [AW-1:0]      pipe_addr_ff, pipe_addr_in;
   logic [WORD_W-1:0]  pipe_hash_ff, pipe_hash_in;
   req_word_type       item_ff, item_in;
   logic [COUNT_W-1:0] count_ff, count_in, count_base;
   logic [WORD_W-1:0]  rd_val_ff, rd_val_in;
   logic               hit_ff, hit_in;
   logic               err_ff, err_in;
   logic               accept;
   logic               idx_ok;
   logic               is_indexed;
   logic [AW-1:0]      item_addr;
   logic [WORD_W-1:0]  merged;

   // The count in effect saturates at the store depth.
   assign n_eff = (IW'(active_regs) > IW'(MAX_REGS)) ? IW'(MAX_REGS) : IW'(active_regs);
   assign idx_ok = IW'(req_word.reg_index) < n_eff;
   assign is_indexed = req_word.req_type inside {REQ_MERGE, REQ_COMPARE, REQ_READ, REQ_WRITE};
   assign accept = req_valid && (state_ff == ST_IDLE);
   assign item_addr = AW'(item_ff.reg_index);
   assign merged = (item_ff.reg_value > mem_rd_data) ? item_ff.reg_value : mem_rd_data;
   assign count_base = item_ff.restart_count ? '0 : count_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (cnt_ff[AW-1:0] == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               if (req_word.req_type == REQ_ADD) begin
                  state_in = (n_eff == '0) ? ST_DONE : ST_ADD;
               end else if (is_indexed && idx_ok) begin
                  state_in = ST_LOOKUP;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_ADD: begin
            if (cnt_ff == n_eff - IW'(1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN:  state_in = ST_DONE;
         ST_LOOKUP: state_in = ST_MODIFY;
         ST_MODIFY: state_in = ST_DONE;
         ST_DONE: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_CLEAR;
      endcase
   end

   // Handshake and memory port control.
   always_comb begin
      req_ready   = (state_ff == ST_IDLE);
      res_valid   = (state_ff == ST_DONE);
      mem_wr_en   = 1'b0;
      mem_wr_addr = pipe_addr_ff;
      mem_wr_data = pipe_hash_ff;
      mem_rd_en   = 1'b0;
      mem_rd_addr = cnt_ff[AW-1:0];
      case (state_ff)
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = cnt_ff[AW-1:0];
            mem_wr_data = '0;
         end
         ST_ADD, ST_DRAIN: begin
            // Read of word i overlaps the write-back of word i-1.
            mem_rd_en = (state_ff == ST_ADD);
            if (pipe_valid_ff && (pipe_hash_ff > mem_rd_data)) begin
               mem_wr_en = 1'b1;
            end
         end
         ST_LOOKUP: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = item_addr;
         end
         ST_MODIFY: begin
            mem_wr_addr = item_addr;
            mem_wr_data = item_ff.reg_value;
            if (item_ff.req_type == REQ_WRITE) begin
               mem_wr_en = 1'b1;
            end else if ((item_ff.req_type == REQ_MERGE) &&
                         (item_ff.reg_value > mem_rd_data)) begin
               mem_wr_en = 1'b1;
            end
         end
         default: begin
            mem_wr_en = 1'b0;
         end
      endcase
   end

   // Datapath next values.
   always_comb begin
      cnt_in        = cnt_ff;
      hash_in       = hash_ff;
      step_in       = step_ff;
      item_in       = item_ff;
      count_in      = count_ff;
      rd_val_in     = rd_val_ff;
      hit_in        = hit_ff;
      err_in        = err_ff;
      pipe_valid_in = (state_ff == ST_ADD);
      pipe_addr_in  = cnt_ff[AW-1:0];
      pipe_hash_in  = hash_ff;
      case (state_ff)
         ST_CLEAR: begin
            cnt_in = (cnt_ff[AW-1:0] == LAST_ADDR) ? '0 : cnt_ff + IW'(1);
         end
         ST_IDLE: begin
            cnt_in = '0;
            if (accept) begin
               item_in   = req_word;
               hash_in   = req_word.key_hash[WORD_W-1:0];
               step_in   = req_word.key_hash[HASH_W-1:WORD_W];
               rd_val_in = '0;
               hit_in    = 1'b0;
               err_in    = is_indexed && !idx_ok;
            end
         end
         ST_ADD: begin
            // a + i*b built up one step of b at a time.
            cnt_in  = cnt_ff + IW'(1);
            hash_in = hash_ff + step_ff;
         end
         ST_MODIFY: begin
            case (item_ff.req_type)
               REQ_MERGE: rd_val_in = merged;
               REQ_COMPARE: begin
                  rd_val_in = mem_rd_data;
                  hit_in    = (mem_rd_data == item_ff.reg_value);
                  if ((mem_rd_data == item_ff.reg_value) && (count_base != COUNT_MAX)) begin
                     count_in = count_base + COUNT_W'(1);
                  end else begin
                     count_in = count_base;
                  end
               end
               REQ_READ:  rd_val_in = mem_rd_data;
               REQ_WRITE: rd_val_in = item_ff.reg_value;
               default:   rd_val_in = '0;
            endcase
         end
         default: begin
            cnt_in = cnt_ff;
         end
      endcase
   end

   always_comb begin
      res_word.read_value  = rd_val_ff;
      res_word.match       = hit_ff;
      res_word.match_count = count_ff;
      res_word.index_error = err_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         cnt_ff        <= '0;
         pipe_valid_ff <= 1'b0;
         count_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         pipe_valid_ff <= pipe_valid_in;
         count_ff      <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      hash_ff      <= hash_in;
      step_ff      <= step_in;
      pipe_addr_ff <= pipe_addr_in;
      pipe_hash_ff <= pipe_hash_in;
      item_ff      <= item_in;
      rd_val_ff    <= rd_val_in;
      hit_ff       <= hit_in;
      err_ff       <= err_in;
   end

   // A write and a read never meet on the same word in one cycle.
   assert property (@(posedge clock) disable iff (reset)
      (mem_wr_en && mem_rd_en) |-> (mem_wr_addr != mem_rd_addr))
      else $error("same-word read and write overlap");

   // The add sweep stays inside the active words.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ADD) |-> (cnt_ff < n_eff))
      else $error("add sweep ran past the active words");

   // No write-back is left pending once a result is offered.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> !pipe_valid_ff)
      else $error("result offered with a pending write-back");

   // The equal count moves only after a modify step or a reset.
   assert property (@(posedge clock) disable iff (reset)
      !$stable(count_ff) |-> ($past(state_ff) == ST_MODIFY || $past(reset)))
      else $error("equal count changed outside a compare");

endmodule

@@ hdl/minhash_sketch_update.sv @@
// Top level of the sketch update block. Depends on msk_pkg, msk_mem, msk_engine.
// Throughput: one word at a time. An add sweeps the min(active_registers, MAX_REGS)
// active words with one read-modify-write of the store per cycle, and skips the
// sweep when no word is active; merge, compare, read and write do one lookup and
// one modify step; index errors and unknown types go straight to the result.
// Reset: synchronous; a clearing pass zeroes all MAX_REGS words, req_ready low.
module minhash_sketch_update
   import msk_pkg::*;
#(
   parameter int MAX_REGS = 256
) (
   input  logic                clock,
   input  logic                reset,
   // Request channel.
   input  logic                req_valid,
   output logic                req_ready,
   input  req_word_type        req_word,
   // Result channel.
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rsp_word_type        rsp_word,
   // Configuration port.
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [PADDR_W-1:0]  paddr,
   input  logic [PDATA_W-1:0]  pwdata,
   output logic [PDATA_W-1:0]  prdata,
   output logic                pready
);

   localparam int AW = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1;

   logic [ACTIVE_W-1:0] active_ff, active_in;
   logic                csr_write;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_word_type        rsp_word_ff, rsp_word_in;
   logic                res_valid;
   logic                res_take;
   rsp_word_type        res_word;
   logic                mem_wr_en;
   logic [AW-1:0]       mem_wr_addr;
   logic [WORD_W-1:0]   mem_wr_data;
   logic                mem_rd_en;
   logic [AW-1:0]       mem_rd_addr;
   logic [WORD_W-1:0]   mem_rd_data;

   // The only register is the active word count at word index zero. Bit 2 of
   // paddr selects the word; the low two bits are the byte offset within it.
   // The port never stalls, so a write lands in the access cycle.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready && (paddr[2] == CSR_ACTIVE_IDX);
   assign active_in = csr_write ? pwdata[ACTIVE_W-1:0] : active_ff;

   always_comb begin
      prdata = '0;
      if (paddr[2] == CSR_ACTIVE_IDX) begin
         prdata = PDATA_W'(active_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= ACTIVE_RESET;
      end else begin
         active_ff <= active_in;
      end
   end

   // The output register decouples the engine from the result channel. The
   // engine hands over a finished word whenever this register is empty or is
   // being emptied in the same cycle, so the engine goes back to idle and can
   // take the next request word while this one still waits for rsp_ready.
   assign res_take     = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in = (res_valid && res_take) || (rsp_valid_ff && !rsp_ready);
   assign rsp_word_in  = (res_valid && res_take) ? res_word : rsp_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // The engine sequences every access to the store: the clearing pass after
   // reset, the add sweep that raises each active word to a + i*b, and the
   // single-word read-modify-write of merge, compare, read and write.
   msk_engine #(
      .MAX_REGS (MAX_REGS)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .active_regs (active_ff),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_word    (req_word),
      .res_valid   (res_valid),
      .res_take    (res_take),
      .res_word    (res_word),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   // The sketch words themselves, one synchronous memory of MAX_REGS entries.
   msk_mem #(
      .DEPTH (MAX_REGS)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

@@ tb/tb_top.sv @@
// Self-checking bench for the minhash sketch update block: random and directed
// request words, a mirror of the sketch store and match counter, and APB setup.
// Depends on msk_pkg and the RTL of minhash_sketch_update.
module tb_top;
   import msk_pkg::*;

   localparam int SKETCH_DEPTH  = 256;
   localparam int STALL_LIMIT   = 5000;
   localparam int SETTLE_CYCLES = 4;
   localparam int END_HOLD      = 300;
   localparam int PHASES        = 8;
   localparam int COUNT_PHASE   = 5;

   // Request codes 5 to 7 have no meaning; the block must pass them by.
   localparam logic [KIND_W-1:0] REQ_FIRST_UNUSED = REQ_WRITE + 3'd1;
   localparam logic [KIND_W-1:0] REQ_LAST_UNUSED  = 3'd7;

   localparam logic [PADDR_W-1:0] CSR_ACTIVE_ADDR = {CSR_ACTIVE_IDX, 2'b00};

   // The mirror keeps its own copy of the sketch store, the running equal count
   // and the active register count. Every accepted request word is played on
   // the copy, and the result word it must cause is queued in order.
   class sketch_mirror;
      bit   [WORD_W-1:0]   words [SKETCH_DEPTH];
      logic [ACTIVE_W-1:0] active;
      logic [COUNT_W-1:0]  equal_count;
      rsp_word_type        owed_words [$];
      int                  failures;

      function new();
         foreach (words[i]) words[i] = '0;
         active      = ACTIVE_RESET;
         equal_count = '0;
         failures    = 0;
      endfunction

      function void report(string msg);
         failures++;
         if (failures <= 10) $display("[%0t] %s", $time, msg);
      endfunction

      // Register values above the store depth saturate at the depth.
      function logic [ACTIVE_W-1:0] live_count();
         return (active > ACTIVE_W'(SKETCH_DEPTH)) ? ACTIVE_W'(SKETCH_DEPTH) : active;
      endfunction

      function void apply_request(req_word_type w);
         rsp_word_type        e;
         logic [ACTIVE_W-1:0] n;
         logic [WORD_W-1:0]   a;
         logic [WORD_W-1:0]   b;
         logic [WORD_W-1:0]   h;
         e = '0;
         n = live_count();
         a = w.key_hash[WORD_W-1:0];
         b = w.key_hash[HASH_W-1:WORD_W];
         if (w.req_type == REQ_ADD) begin
            // Word i is raised to a + i*b, all in 32-bit wraparound arithmetic.
            for (int i = 0; i < int'(n); i++) begin
               h = a + WORD_W'(i) * b;
               if (h > words[i]) words[i] = h;
            end
         end else if (w.req_type <= REQ_WRITE) begin
            if ({1'b0, w.reg_index} >= n) begin
               // An out-of-range index leaves everything alone, restart included.
               e.index_error = 1'b1;
            end else begin
               case (w.req_type)
                  REQ_MERGE: begin
                     if (w.reg_value > words[w.reg_index]) words[w.reg_index] = w.reg_value;
                  end
                  REQ_COMPARE: begin
                     if (w.restart_count) equal_count = '0;
                     if (words[w.reg_index] == w.reg_value) begin
                        e.match = 1'b1;
                        if (equal_count < COUNT_MAX) equal_count++;
                     end
                  end
                  REQ_WRITE: begin
                     words[w.reg_index] = w.reg_value;
                  end
                  default: begin
                  end
               endcase
               e.read_value = words[w.reg_index];
            end
         end
         e.match_count = equal_count;
         owed_words.push_back(e);
      endfunction

      function void check_result(rsp_word_type got);
         rsp_word_type e;
         if (owed_words.size() == 0) begin
            report($sformatf("result word with nothing owed: value %h match %b count %0d err %b",
                             got.read_value, got.match, got.match_count, got.index_error));
            return;
         end
         e = owed_words.pop_front();
         if (got.read_value !== e.read_value || got.match !== e.match ||
             got.match_count !== e.match_count || got.index_error !== e.index_error) begin
            report($sformatf({"result mismatch: expected value %h match %b count %0d err %b,",
                              " got value %h match %b count %0d err %b"},
                             e.read_value, e.match, e.match_count, e.index_error,
                             got.read_value, got.match, got.match_count, got.index_error));
         end
      endfunction

      function void finish_check();
         if (owed_words.size() != 0)
            report($sformatf("%0d result words never arrived", owed_words.size()));
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   req_word_type        req_word;
   logic                rsp_valid;
   logic                rsp_ready;
   rsp_word_type        rsp_word;
   logic                psel;
   logic                penable;
   logic                pwrite;
   logic [PADDR_W-1:0]  paddr;
   logic [PDATA_W-1:0]  pwdata;
   logic [PDATA_W-1:0]  prdata;
   logic                pready;

   sketch_mirror        mirror = new();
   bit                  calm = 1'b0;
   int                  stall_cycles = 0;

   minhash_sketch_update #(
      .MAX_REGS(SKETCH_DEPTH)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_word (req_word),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_word (rsp_word),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always #10 clock = ~clock;

   // Both channels are sampled at the rising edge, before the block's own
   // registers move. A request word is played on the mirror when it is taken,
   // and a result word is checked when it is taken.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) mirror.apply_request(req_word);
         if (rsp_valid && rsp_ready) mirror.check_result(rsp_word);
      end
   end

   // The watchdog counts cycles in which no word moves on any port.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable && pready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
   end

   initial begin
      wait (stall_cycles >= STALL_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
   end

   // The receiver holds off in random bursts between runs of readiness, and
   // stays ready throughout once the bench turns calm.
   initial begin
      rsp_ready <= 1'b0;
      @(negedge clock);
      forever begin
         if (!calm && $urandom_range(0, 2) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 30)) @(negedge clock);
      end
   end

   // Sender gaps: sometimes valid drops for a burst before the next word.
   task automatic pace();
      int gap;
      if (!calm && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 19);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // Presents one request word at a falling edge and holds it until taken.
   // It returns at the falling edge after the handshake, so a following word
   // can be put up without valid dropping in between.
   task automatic send_request(req_word_type w);
      pace();
      req_word  <= w;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic push_item(logic [KIND_W-1:0] kind, logic [HASH_W-1:0] hash,
                            logic [IDX_W-1:0] idx, logic [WORD_W-1:0] value, logic restart);
      req_word_type w;
      w.req_type      = kind;
      w.key_hash      = hash;
      w.reg_index     = idx;
      w.reg_value     = value;
      w.restart_count = restart;
      send_request(w);
   endtask

   // Waits until every owed result word has come back, then lets the block
   // settle so that a register write finds it idle.
   task automatic drain();
      req_valid <= 1'b0;
      while (mirror.owed_words.size() != 0) @(posedge clock);
      @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Writes the active register count over APB, then reads it back. Bits of
   // pwdata above the register width carry junk now and then; the block keeps
   // only the low nine bits.
   task automatic set_active(logic [ACTIVE_W-1:0] value);
      logic [PDATA_W-1:0] seen;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ACTIVE_ADDR;
      pwdata  <= {($urandom_range(0, 2) == 0) ? 23'($urandom) : 23'd0, value};
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      mirror.active = value;
      @(negedge clock);
      psel    <= 1'b1;
      paddr   <= CSR_ACTIVE_ADDR;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      seen = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      if (seen[ACTIVE_W-1:0] !== value)
         mirror.report($sformatf("active count read back %0d, written %0d",
                                 seen[ACTIVE_W-1:0], value));
   endtask

   // Builds one random request word. Most indexes fall inside the active
   // range and most compares carry the word the store is known to hold, so
   // that hits and the running count get real exercise. In a counting run
   // nearly every word is a hitting compare without restart, which drives
   // the count into saturation.
   function automatic req_word_type rand_request(bit count_run);
      req_word_type        w;
      logic [ACTIVE_W-1:0] n;
      int                  roll;
      n    = mirror.live_count();
      roll = $urandom_range(0, 99);
      if (count_run)
         w.req_type = (roll < 97) ? REQ_COMPARE : REQ_READ;
      else if (roll < 20) w.req_type = REQ_ADD;
      else if (roll < 35) w.req_type = REQ_MERGE;
      else if (roll < 60) w.req_type = REQ_COMPARE;
      else if (roll < 75) w.req_type = REQ_READ;
      else if (roll < 92) w.req_type = REQ_WRITE;
      else w.req_type = KIND_W'($urandom_range(REQ_FIRST_UNUSED, REQ_LAST_UNUSED));

      case ($urandom_range(0, 9))
         0:       w.key_hash = '0;
         1:       w.key_hash = '1;
         2:       w.key_hash = {32'd0, 32'($urandom)};
         default: w.key_hash = {32'($urandom), 32'($urandom)};
      endcase

      if (n != 0 && $urandom_range(0, 9) != 0)
         w.reg_index = IDX_W'($urandom_range(n - 1, 0));
      else
         w.reg_index = IDX_W'($urandom_range(0, 255));

      case ($urandom_range(0, 9))
         0:       w.reg_value = '0;
         1:       w.reg_value = '1;
         default: w.reg_value = 32'($urandom);
      endcase
      if (w.req_type == REQ_COMPARE && (count_run || $urandom_range(0, 9) < 7))
         w.reg_value = mirror.words[w.reg_index];

      w.restart_count = count_run ? 1'b0 : ($urandom_range(0, 9) == 0);
      return w;
   endfunction

   initial begin
      logic [ACTIVE_W-1:0] phase_active [PHASES];
      int                  phase_len    [PHASES];

      reset     = 1'b1;
      req_valid = 1'b0;
      req_word  = '0;
      psel      = 1'b0;
      penable   = 1'b0;
      pwrite    = 1'b0;
      paddr     = '0;
      pwdata    = '0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // Directed words at the reset count: a clean store, adds with zero,
      // unit step and all-ones hashes, merges above and below the stored word,
      // writes, compares with and without restart, and the unused codes.
      push_item(REQ_READ,    '0, 8'd0,   '0, 1'b0);
      push_item(REQ_READ,    '0, 8'd255, '0, 1'b0);
      push_item(REQ_ADD,     '0, 8'd0,   '0, 1'b0);
      push_item(REQ_ADD,     {32'd1, 32'd0}, 8'd0, '0, 1'b0);
      push_item(REQ_READ,    '0, 8'd255, '0, 1'b0);
      push_item(REQ_ADD,     '1, 8'd255, '1, 1'b1);
      push_item(REQ_MERGE,   '0, 8'd0,   '0, 1'b0);
      push_item(REQ_MERGE,   '0, 8'd255, '1, 1'b0);
      push_item(REQ_MERGE,   '0, 8'd7,   32'd1, 1'b0);
      push_item(REQ_WRITE,   '0, 8'd5,   32'h1234_5678, 1'b0);
      push_item(REQ_WRITE,   '0, 8'd255, '0, 1'b0);
      push_item(REQ_COMPARE, '0, 8'd5,   32'h1234_5678, 1'b1);
      push_item(REQ_COMPARE, '0, 8'd255, 32'd1, 1'b0);
      push_item(REQ_COMPARE, '0, 8'd255, '0, 1'b0);
      push_item(REQ_COMPARE, '0, 8'd0,   '0, 1'b1);
      push_item(REQ_READ,    '0, 8'd5,   '0, 1'b0);
      for (int k = int'(REQ_FIRST_UNUSED); k <= int'(REQ_LAST_UNUSED); k++)
         push_item(KIND_W'(k), {32'($urandom), 32'($urandom)}, 8'($urandom),
                   32'($urandom), 1'b1);
      push_item(REQ_ADD, {32'($urandom), 32'($urandom)}, 8'd255, 32'($urandom), 1'b1);
      drain();

      // With one active word every index above zero is an error, and a
      // restart carried by an erroneous compare must not clear the count.
      set_active(9'd1);
      push_item(REQ_MERGE,   '0, 8'd1,   '1, 1'b0);
      push_item(REQ_COMPARE, '0, 8'd1,   '0, 1'b1);
      push_item(REQ_WRITE,   '0, 8'd200, '1, 1'b0);
      push_item(REQ_READ,    '0, 8'd0,   '0, 1'b0);
      push_item(REQ_ADD,     {32'($urandom), 32'($urandom)}, 8'd0, '0, 1'b0);
      drain();

      // With no active word an add changes nothing and every index fails.
      set_active(9'd0);
      push_item(REQ_ADD,  '1, 8'd0, '0, 1'b0);
      push_item(REQ_READ, '0, 8'd0, '0, 1'b0);
      drain();

      // Random phases over several counts: the reset value, the largest
      // field value (saturating at the store depth), tiny and odd sizes, a
      // random one, a long counting run, a single word, and a calm last part.
      phase_active = '{9'd256, 9'd511, 9'd2, 9'd37, 9'd0, 9'd300, 9'd1, 9'd256};
      phase_len    = '{110, 70, 60, 70, 70, 560, 40, 80};
      phase_active[4] = ACTIVE_W'($urandom_range(3, 255));
      for (int p = 0; p < PHASES; p++) begin
         if (p == PHASES - 1) calm = 1'b1;
         set_active(phase_active[p]);
         if (p == COUNT_PHASE)
            push_item(REQ_COMPARE, '0, 8'd0, mirror.words[0], 1'b1);
         for (int k = 0; k < phase_len[p]; k++)
            send_request(rand_request(p == COUNT_PHASE));
         drain();
      end

      repeat (END_HOLD) @(posedge clock);
      mirror.finish_check();
      if (mirror.failures == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
